// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the top-level RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/wpph_pkg.sv -----
`timescale 1ns / 1ps

package wpph_pkg;

	localparam int NUM_AXES       = 2;
	localparam int AXIS_X         = 0;
	localparam int AXIS_Y         = 1;
	localparam int POS_W          = 24;
	localparam int ERR_W          = POS_W + 1;
	localparam int GAIN_W         = 16;
	localparam int LIMIT_W        = 16;
	localparam int CMD_W          = LIMIT_W + 1;
	localparam int FRAC_BITS      = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 24;

	localparam int WINDOW_LEN_DEF = 7;
	localparam int MID_DEPTH_DEF  = 4;
	localparam int OUT_DEPTH_DEF  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_X  = 3'd0,
		REG_TARGET_Y  = 3'd1,
		REG_GAIN_P    = 3'd2,
		REG_GAIN_I    = 3'd3,
		REG_GAIN_D    = 3'd4,
		REG_VEL_LIMIT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  target_x;
		logic signed [POS_W-1:0]  target_y;
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIMIT_W-1:0]       vel_limit;
	} wpph_cfg_t;

	typedef logic [NUM_AXES-1:0][ERR_W-1:0] err_vec_t;
	typedef logic [NUM_AXES-1:0][CMD_W-1:0] cmd_vec_t;

endpackage

// ----- rtl/core/wpph_fifo.sv -----
`timescale 1ns / 1ps

module wpph_fifo import wpph_pkg::*; #(
	parameter int WIDTH = CMD_W * NUM_AXES,
	parameter int DEPTH = OUT_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/wpph_front.sv -----
`timescale 1ns / 1ps

module wpph_front import wpph_pkg::*; (
	input  wpph_cfg_t               cfg,
	input  logic                    push,
	input  logic                    full,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	output logic                    mid_push,
	output err_vec_t                mid_err
);

	// The error is one bit wider than the position so the subtraction never wraps.
	always_comb begin
		mid_err[AXIS_X] = ERR_W'(cfg.target_x) - ERR_W'(pos_x);
		mid_err[AXIS_Y] = ERR_W'(cfg.target_y) - ERR_W'(pos_y);
	end

	assign mid_push = push && !full;

endmodule

// ----- rtl/core/wpph_back.sv -----
`timescale 1ns / 1ps

module wpph_back import wpph_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  wpph_cfg_t cfg,
	input  logic      en,
	input  logic      in_valid,
	input  err_vec_t  in_err,
	output logic      out_valid,
	output cmd_vec_t  out_cmd
);

	localparam int SUM_W = ERR_W + $clog2(WINDOW_LEN);
	localparam int DIF_W = ERR_W + 1;
	localparam int PP_W  = GAIN_W + ERR_W;
	localparam int PI_W  = GAIN_W + SUM_W;
	localparam int PD_W  = GAIN_W + DIF_W;
	localparam int DRV_W = PI_W - FRAC_BITS + 2;

	logic v_s1_q;
	logic v_s2_q;
	logic v_s3_q;
	logic load;

	assign load      = en && in_valid;
	assign out_valid = en && v_s3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else if (en) begin
			v_s1_q <= in_valid;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		logic signed [ERR_W-1:0]   hist_q [WINDOW_LEN];
		logic signed [SUM_W-1:0]   sum_q;
		logic signed [ERR_W-1:0]   err_new;
		logic signed [SUM_W-1:0]   sum_next;
		logic signed [DIF_W-1:0]   diff_next;
		logic signed [ERR_W-1:0]   err_s1;
		logic signed [SUM_W-1:0]   sum_s1;
		logic signed [DIF_W-1:0]   diff_s1;
		logic signed [PP_W-1:0]    prod_p;
		logic signed [PI_W-1:0]    prod_i;
		logic signed [PD_W-1:0]    prod_d;
		logic signed [PP_W-FRAC_BITS-1:0] term_p_s2;
		logic signed [PI_W-FRAC_BITS-1:0] term_i_s2;
		logic signed [PD_W-FRAC_BITS-1:0] term_d_s2;
		logic signed [DRV_W-1:0]   drive;
		logic signed [DRV_W-1:0]   lim;
		logic signed [DRV_W-1:0]   clamped;
		logic [CMD_W-1:0]          cmd_s3;

		// The window sum is kept as a running total: add the newest, drop the oldest.
		always_comb begin
			err_new   = $signed(in_err[a]);
			sum_next  = sum_q + SUM_W'(err_new) - SUM_W'(hist_q[WINDOW_LEN-1]);
			diff_next = DIF_W'(err_new) - DIF_W'(hist_q[0]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					hist_q[i] <= '0;
				end
				sum_q <= '0;
			end else if (load) begin
				hist_q[0] <= err_new;
				for (int i = 1; i < WINDOW_LEN; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
				sum_q <= sum_next;
			end
		end

		always_comb begin
			prod_p = PP_W'(cfg.gain_p) * PP_W'(err_s1);
			prod_i = PI_W'(cfg.gain_i) * PI_W'(sum_s1);
			prod_d = PD_W'(cfg.gain_d) * PD_W'(diff_s1);
		end

		// Dropping the fraction bits of a signed product rounds toward minus infinity.
		always_comb begin
			drive = DRV_W'(term_p_s2) + DRV_W'(term_i_s2) + DRV_W'(term_d_s2);
			lim   = DRV_W'($signed({1'b0, cfg.vel_limit}));
			clamped = drive;
			if (drive >= lim) begin
				clamped = lim;
			end
			if (clamped <= -lim) begin
				clamped = -lim;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				err_s1    <= err_new;
				sum_s1    <= sum_next;
				diff_s1   <= diff_next;
				term_p_s2 <= $signed(prod_p[PP_W-1:FRAC_BITS]);
				term_i_s2 <= $signed(prod_i[PI_W-1:FRAC_BITS]);
				term_d_s2 <= $signed(prod_d[PD_W-1:FRAC_BITS]);
				cmd_s3    <= clamped[CMD_W-1:0];
			end
		end

		assign out_cmd[a] = cmd_s3;
	end

endmodule

// ----- rtl/core/windowed_pid_position_hold.sv -----
// Channel   Handshake          Payload
// input     push / full        pos_x, pos_y
// result    empty / pop        cmd_x, cmd_y
// config    cfg_we             cfg_index, cfg_data
//
// One position transaction is taken per clock while full is low; the running
// window sum is a registered total updated on every loaded sample, which sets that rate.
// A result passes through the input queue, back stages s1, s2, s3 and the result queue.
// Reset clears configuration, the error window and all queues.
// A full result queue freezes the back pipeline; the input queue then fills and full rises.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module windowed_pid_position_hold import wpph_pkg::*; #(
	parameter int WINDOW_LEN = WINDOW_LEN_DEF,
	parameter int MID_DEPTH  = MID_DEPTH_DEF,
	parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [CMD_W-1:0] cmd_x,
	output logic signed [CMD_W-1:0] cmd_y,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	wpph_cfg_t cfg_q;
	logic      mid_push;
	err_vec_t  mid_din;
	err_vec_t  mid_dout;
	logic      mid_empty;
	logic      mid_pop;
	logic      back_en;
	logic      out_push;
	cmd_vec_t  out_din;
	cmd_vec_t  out_dout;
	logic      out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TARGET_X:  cfg_q.target_x  <= cfg_data[POS_W-1:0];
				REG_TARGET_Y:  cfg_q.target_y  <= cfg_data[POS_W-1:0];
				REG_GAIN_P:    cfg_q.gain_p    <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i    <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d    <= cfg_data[GAIN_W-1:0];
				REG_VEL_LIMIT: cfg_q.vel_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	wpph_front u_front (
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.mid_push (mid_push),
		.mid_err  (mid_din)
	);

	wpph_fifo #(
		.WIDTH (NUM_AXES * ERR_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_din),
		.full   (full),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.empty  (mid_empty)
	);

	assign back_en = !out_full;
	assign mid_pop = back_en && !mid_empty;

	wpph_back #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.en        (back_en),
		.in_valid  (mid_pop),
		.in_err    (mid_dout),
		.out_valid (out_push),
		.out_cmd   (out_din)
	);

	wpph_fifo #(
		.WIDTH (NUM_AXES * CMD_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (out_din),
		.full   (out_full),
		.pop    (pop),
		.dout   (out_dout),
		.empty  (empty)
	);

	assign cmd_x = $signed(out_dout[AXIS_X]);
	assign cmd_y = $signed(out_dout[AXIS_Y]);

	`ASSERT_IMPLIES(a_out_no_overflow, out_push, !out_full, "result queue overflow")
	`ASSERT_IMPLIES(a_mid_no_underflow, mid_pop, !mid_empty, "input queue underflow")
	`ASSERT_NEXT(a_accept_lands, push && !full, !mid_empty, "accepted transaction lost")

endmodule
